[sv/pcxrle_pkg.sv]
// Shared types and constants for the PCX run-length scanline decoder.
package pcxrle_pkg;

    // Widths of the configuration registers and result fields
    localparam int CFG_W   = 14;
    localparam int PLN_W   = 3;
    localparam int OUT_W   = 14;
    localparam int RUN_W   = 6;
    localparam int BYTE_W  = 8;

    // Byte classification: both top bits set marks a run header
    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

    // Register reset values
    localparam logic [CFG_W-1:0] BPL_RST    = 14'd320;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd200;
    localparam logic [PLN_W-1:0] PLANES_RST = 3'd1;
    localparam logic [PLN_W-1:0] PLANES_MAX = 3'd4;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BYTES_PER_LINE = 2'd0,
        REG_IMAGE_WIDTH    = 2'd1,
        REG_IMAGE_HEIGHT   = 2'd2,
        REG_PLANE_COUNT    = 2'd3
    } t_reg_idx;

    // Effective geometry (zero bytes per line, height and plane count already forced to one, planes saturated)
    typedef struct packed {
        logic [CFG_W-1:0] bytes_per_line;
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [PLN_W-1:0] plane_count;
    } t_cfg;

    // One decode command: a value and how many positions it fills
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [RUN_W-1:0]  count;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] pixel_value;
        logic [OUT_W-1:0]  row_index;
        logic [OUT_W-1:0]  column_index;
        logic [1:0]        plane_index;
        logic              last_of_run;
    } t_pix;

endpackage

[sv/pcxrle_fifo.sv]
// Small register-based first-in first-out queue.
module pcxrle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill-count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[sv/pcxrle_front.sv]
// Front end: classifies encoded bytes into literal and run commands.
module pcxrle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    output logic                 o_ready,
    input  logic                 i_cmd_full,
    output logic                 o_cmd_push,
    output pcxrle_pkg::t_cmd     o_cmd
);
    import pcxrle_pkg::*;

    logic             r_await, n_await;
    logic [RUN_W-1:0] r_count, n_count;
    logic             accept;
    logic             is_header;

    assign o_ready   = !i_cmd_full;
    assign accept    = i_valid && !i_cmd_full;
    assign is_header = ((i_data_byte & RUN_MARK) == RUN_MARK);

    // Classify the beat: value byte of a run, run header, or literal
    always_comb begin
        n_await     = r_await;
        n_count     = r_count;
        o_cmd_push  = 1'b0;
        o_cmd.value = i_data_byte;
        o_cmd.count = RUN_W'(1);
        if (accept) begin
            priority if (r_await) begin
                n_await     = 1'b0;
                o_cmd.count = r_count;
                // zero-length run consumes its value byte and fills nothing
                o_cmd_push  = (r_count != '0);
            end else if (is_header) begin
                n_await = 1'b1;
                n_count = RUN_W'(i_data_byte & RUN_MASK);
            end else begin
                o_cmd_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_count <= '0;
        end else begin
            r_await <= n_await;
            r_count <= n_count;
        end
    end

endmodule

[sv/pcxrle_back.sv]
// Back end: emits pixels; walks col/plane/row a position per cycle unless stalled.
module pcxrle_back #(
    parameter int COORD_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcxrle_pkg::t_cfg     i_cfg,
    input  logic                 i_cmd_valid,
    input  pcxrle_pkg::t_cmd     i_cmd,
    output logic                 o_cmd_pop,
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output pcxrle_pkg::t_pix     o_out
);
    import pcxrle_pkg::*;

    // Compare width: room for the wider of counter and register, plus a carry
    localparam int XW = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;

    logic [COORD_BITS-1:0] r_col,   n_col;
    logic [COORD_BITS-1:0] r_row,   n_row;
    logic [1:0]            r_plane, n_plane;
    logic                  r_fin,   n_fin;
    logic [RUN_W-1:0]      r_done,  n_done;

    logic [XW-1:0]    col_x, col1, bpl_x, iw_x, row1, gap_len;
    logic [RUN_W-1:0] rem_after;
    logic             step, visible, col_wrap, plane_wrap, row_wrap;
    logic             end_wrap, next_vis, more;

    assign col_x     = XW'(r_col);
    assign col1      = col_x + XW'(1);
    assign bpl_x     = XW'(i_cfg.bytes_per_line);
    assign iw_x      = XW'(i_cfg.image_width);
    assign row1      = XW'(r_row) + XW'(1);
    assign col_wrap   = (col1 >= bpl_x);
    assign plane_wrap = (({1'b0, r_plane} + PLN_W'(1)) >= i_cfg.plane_count);
    assign row_wrap   = (row1 >= XW'(i_cfg.image_height));
    assign end_wrap   = plane_wrap && row_wrap;
    assign visible    = (col_x < iw_x);
    assign rem_after  = i_cmd.count - r_done - RUN_W'(1);
    assign step       = i_cmd_valid && !r_fin && !i_out_full;

    // Look ahead: is another visible position reached within this run?
    always_comb begin
        if (!col_wrap && (col1 < iw_x)) begin
            gap_len  = XW'(1);
            next_vis = 1'b1;
        end else begin
            // next visible spot is column zero after the line wrap
            gap_len  = col_wrap ? XW'(1) : (bpl_x - col_x);
            next_vis = (i_cfg.image_width != '0) && !end_wrap;
        end
        more = next_vis && (XW'(rem_after) >= gap_len);
    end

    // Position walk and command retirement
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        n_fin   = r_fin;
        n_done  = r_done;
        // once the image is complete every command is dropped
        o_cmd_pop = i_cmd_valid && r_fin;
        if (step) begin
            if (col_wrap) begin
                n_col = '0;
                if (plane_wrap) begin
                    n_plane = '0;
                    if (row_wrap) begin
                        n_row = '0;
                        n_fin = 1'b1;
                    end else begin
                        n_row = row1[COORD_BITS-1:0];
                    end
                end else begin
                    n_plane = r_plane + 2'd1;
                end
            end else begin
                n_col = col1[COORD_BITS-1:0];
            end
            if ((rem_after == '0) || (col_wrap && end_wrap)) begin
                o_cmd_pop = 1'b1;
                n_done    = '0;
            end else begin
                n_done = r_done + RUN_W'(1);
            end
        end
    end

    // Result beat for a visible position
    assign o_out_push         = step && visible;
    assign o_out.pixel_value  = i_cmd.value;
    assign o_out.row_index    = OUT_W'(XW'(r_row));
    assign o_out.column_index = OUT_W'(col_x);
    assign o_out.plane_index  = r_plane;
    assign o_out.last_of_run  = !more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
            r_fin   <= 1'b0;
            r_done  <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
            r_fin   <= n_fin;
            r_done  <= n_done;
        end
    end

endmodule

[sv/pcx_rle_scanline_decoder.sv]
// PCX 8-bit run-length scanline decoder: a literal passes the registered command queue, then the
// registered result queue, to the result ports. The walker covers one position per cycle while a
// command waits, the result queue has room and the image is unfinished; a run of n fills n
// positions (padding included). Input stalls only while the command queue (CMD_DEPTH entries) is full.
// Synchronous active-low reset clears the walk position, the queues and the run state
// and loads the geometry registers with 320 bytes per line, 320 columns, 200 rows, 1 plane.
module pcx_rle_scanline_decoder #(
    parameter int COORD_BITS = 14,
    parameter int CMD_DEPTH  = 2,
    parameter int OUT_DEPTH  = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // encoded byte input
    input  logic                          push,
    output logic                          full,
    input  logic [pcxrle_pkg::BYTE_W-1:0] i_data_byte,
    // pixel output
    output logic                          empty,
    input  logic                          pop,
    output logic [pcxrle_pkg::BYTE_W-1:0] o_pixel_value,
    output logic [pcxrle_pkg::OUT_W-1:0]  o_row_index,
    output logic [pcxrle_pkg::OUT_W-1:0]  o_column_index,
    output logic [1:0]                    o_plane_index,
    output logic                          o_last_of_run,
    // configuration writes
    input  logic                          i_cfg_we,
    input  pcxrle_pkg::t_reg_idx          i_cfg_idx,
    input  logic [pcxrle_pkg::CFG_W-1:0]  i_cfg_data
);
    import pcxrle_pkg::*;

    t_cfg  r_cfg;
    t_cmd  front_cmd, head_cmd;
    t_pix  back_pix, out_pix;
    logic  front_push, cmd_full, cmd_empty, cmd_pop;
    logic  out_push, out_full, front_ready;
    logic [PLN_W-1:0] plane_wr;

    // Geometry registers; zero bytes per line, height or plane count is stored as one and planes saturate at four
    assign plane_wr = i_cfg_data[PLN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_line <= BPL_RST;
            r_cfg.image_width    <= WIDTH_RST;
            r_cfg.image_height   <= HEIGHT_RST;
            r_cfg.plane_count    <= PLANES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BYTES_PER_LINE: begin
                    r_cfg.bytes_per_line <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                end
                REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data;
                end
                REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                end
                REG_PLANE_COUNT: begin
                    priority if (plane_wr == '0) begin
                        r_cfg.plane_count <= PLN_W'(1);
                    end else if (plane_wr > PLANES_MAX) begin
                        r_cfg.plane_count <= PLANES_MAX;
                    end else begin
                        r_cfg.plane_count <= plane_wr;
                    end
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Byte classifier
    pcxrle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (push),
        .i_data_byte (i_data_byte),
        .o_ready     (front_ready),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    assign full = !front_ready;

    // Command queue between classifier and walker
    pcxrle_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (head_cmd)
    );

    // Position walker
    pcxrle_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (back_pix)
    );

    // Result queue
    pcxrle_fifo #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_pix),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_pix)
    );

    assign o_pixel_value  = out_pix.pixel_value;
    assign o_row_index    = out_pix.row_index;
    assign o_column_index = out_pix.column_index;
    assign o_plane_index  = out_pix.plane_index;
    assign o_last_of_run  = out_pix.last_of_run;

endmodule
